// ===== hw/rtl/ccm_pkg.sv =====
// Shared types, codes and reset values for the cruise control mode state machine.
package ccm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [7:0] SpeedLowRst = 8'd80;
  localparam logic [7:0] SpeedHighRst = 8'd170;
  localparam logic [2:0] GearRst = 3'd5;
  localparam logic [7:0] AccelTargetRst = 8'd200;
  localparam logic [7:0] ThrStepRst = 8'd8;
  localparam logic [7:0] ThrLimitRst = 8'd80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_LOW   = 3'd0,
    CFG_SPEED_HIGH  = 3'd1,
    CFG_GEAR        = 3'd2,
    CFG_ACCEL_TGT   = 3'd3,
    CFG_THR_STEP    = 3'd4,
    CFG_THR_LIMIT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    REQ_ACTIVATE    = 4'd0,
    REQ_DEACTIVATE  = 4'd1,
    REQ_ACCEL_START = 4'd2,
    REQ_ACCEL_STOP  = 4'd3,
    REQ_MAX_SPEED   = 4'd4,
    REQ_RESUME      = 4'd5,
    REQ_THR_UP      = 4'd6,
    REQ_THR_DOWN    = 4'd7,
    REQ_SET_SPEED   = 4'd8,
    REQ_SET_RATE    = 4'd9
  } req_type_t;

  typedef enum logic [3:0] {
    MSG_NONE            = 4'd0,
    MSG_ACTIVATE_FIRST  = 4'd1,
    MSG_ACCEL_FIRST     = 4'd2,
    MSG_ALREADY_ACTIVE  = 4'd3,
    MSG_CANNOT_ACTIVATE = 4'd4,
    MSG_DEACTIVATED     = 4'd5,
    MSG_ACCELERATING    = 4'd6,
    MSG_SUSPENDED       = 4'd7,
    MSG_SHOW_SPEED      = 4'd8
  } msg_code_t;

  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] set_value;
    logic       accelerator_pressed;
    logic [2:0] engaged_gear;
    logic       clutch_pressed;
    logic       brake_pressed;
    logic       ignition_on;
    logic       calibrating;
    logic [7:0] throttle_response;
    logic [7:0] vehicle_speed;
    logic       capture_now;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] throttle_rate_out;
    logic [7:0] held_speed_out;
    logic       cruise_accelerating;
    logic       cruise_suspended;
    logic       cruise_active;
    logic [3:0] message_code;
    logic       led_on;
    logic       led_write;
    logic [7:0] maintain_speed;
    logic       maintain_write;
  } out_item_t;

endpackage

// ===== hw/rtl/cruise_control_mode_fsm.sv =====
// Cruise control mode state machine: decodes driver events into cruise commands and status.
//
// A request enters on the in_ stream: in_tuser carries the request type and in_tdata the
// vehicle status snapshot. Every request produces exactly one result on the out_ stream,
// holding the maintain-speed and LED commands, a message code and the cruise status.
// The block has an input register and a result register. A request is held in the input
// register, where the flag, speed and rate updates are worked out in one pass and committed
// together with the result. out_tvalid rises when the request moves on from the input
// register to the result register, and one request per cycle is sustained while the
// receiver takes every result, since each request sees the state left by the one before it.
// When the receiver stalls, the result stays in the output register and the input
// register still accepts one more request; in_tready drops only when both are full.
// Reset clears the cruise flags, the held speed and the throttle rate, empties both registers
// and loads the register defaults. Configuration writes on the cfg_ port take effect at once
// and must only be made while no request is in flight; the block does not enforce this.
module cruise_control_mode_fsm
  import ccm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Fields from bit 0: capture_now, vehicle_speed, throttle_response, calibrating,
  // ignition_on, brake_pressed, clutch_pressed, engaged_gear, accelerator_pressed,
  // set_value, zero fill.
  input  logic [InDataW-1:0]   in_tdata,
  // Fields from bit 0: req_type.
  input  logic [3:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // Fields from bit 0: maintain_write, maintain_speed, led_write, led_on, message_code,
  // cruise_active, cruise_suspended, cruise_accelerating, held_speed_out,
  // throttle_rate_out, zero fill.
  output logic [OutDataW-1:0]  out_tdata,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  logic [7:0] speed_low_r;
  logic [7:0] speed_high_r;
  logic [2:0] gear_r;
  logic [7:0] accel_tgt_r;
  logic [7:0] thr_step_r;
  logic [7:0] thr_limit_r;

  logic       in_valid_r;
  req_type_t  in_req_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic       active_r, active_nxt;
  logic       susp_r, susp_nxt;
  logic       accel_r, accel_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] rate_r, rate_nxt;
  out_item_t  res_nxt;

  logic       advance;
  logic       fire;
  logic       req_ok;
  logic       engage;
  logic [8:0] rate_up;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_low_r  <= SpeedLowRst;
      speed_high_r <= SpeedHighRst;
      gear_r       <= GearRst;
      accel_tgt_r  <= AccelTargetRst;
      thr_step_r   <= ThrStepRst;
      thr_limit_r  <= ThrLimitRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPEED_LOW:  speed_low_r  <= cfg_wdata;
        CFG_SPEED_HIGH: speed_high_r <= cfg_wdata;
        CFG_GEAR:       gear_r       <= cfg_wdata[2:0];
        CFG_ACCEL_TGT:  accel_tgt_r  <= cfg_wdata;
        CFG_THR_STEP:   thr_step_r   <= cfg_wdata;
        CFG_THR_LIMIT:  thr_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign req_ok = !in_item_r.calibrating && in_item_r.ignition_on &&
                  !in_item_r.brake_pressed && !in_item_r.clutch_pressed &&
                  (in_item_r.engaged_gear == gear_r) &&
                  (in_item_r.vehicle_speed >= speed_low_r) &&
                  (in_item_r.vehicle_speed <= speed_high_r);

  assign rate_up = {1'b0, rate_r} + {1'b0, thr_step_r};

  always_comb begin
    active_nxt = active_r;
    susp_nxt   = susp_r;
    accel_nxt  = accel_r;
    held_nxt   = held_r;
    rate_nxt   = rate_r;
    engage     = 1'b0;
    res_nxt    = '0;
    res_nxt.message_code = MSG_NONE;

    unique case (in_req_r)
      REQ_ACTIVATE: begin
        if (req_ok) begin
          if (in_item_r.capture_now) begin
            held_nxt = in_item_r.vehicle_speed;
            rate_nxt = in_item_r.throttle_response;
          end
          engage = 1'b1;
        end else begin
          res_nxt.message_code = MSG_CANNOT_ACTIVATE;
        end
      end
      REQ_DEACTIVATE: begin
        if (active_r) begin
          held_nxt   = '0;
          active_nxt = 1'b0;
          susp_nxt   = 1'b0;
          res_nxt.led_write      = 1'b1;
          res_nxt.maintain_write = 1'b1;
          res_nxt.message_code   = MSG_DEACTIVATED;
        end else begin
          res_nxt.message_code = MSG_ACTIVATE_FIRST;
        end
      end
      REQ_ACCEL_START: begin
        if (active_r && !susp_r) begin
          accel_nxt = 1'b1;
          susp_nxt  = 1'b1;
          res_nxt.maintain_write = 1'b1;
          res_nxt.maintain_speed = accel_tgt_r;
          res_nxt.message_code   = MSG_ACCELERATING;
        end else begin
          res_nxt.message_code = MSG_ACTIVATE_FIRST;
        end
      end
      REQ_ACCEL_STOP: begin
        if (!active_r) begin
          res_nxt.message_code = MSG_ACTIVATE_FIRST;
        end else if (accel_r || in_item_r.accelerator_pressed) begin
          accel_nxt = 1'b0;
          if (req_ok) begin
            held_nxt = in_item_r.vehicle_speed;
            rate_nxt = in_item_r.throttle_response;
            engage   = 1'b1;
          end else begin
            res_nxt.message_code = MSG_CANNOT_ACTIVATE;
          end
        end else begin
          res_nxt.message_code = MSG_ACCEL_FIRST;
        end
      end
      REQ_MAX_SPEED: begin
        engage = active_r;
      end
      REQ_RESUME: begin
        if (active_r && !susp_r) begin
          res_nxt.message_code = MSG_ALREADY_ACTIVE;
        end else if (susp_r) begin
          if (req_ok) begin
            engage = 1'b1;
          end else begin
            res_nxt.message_code = MSG_CANNOT_ACTIVATE;
          end
        end else begin
          res_nxt.message_code = MSG_ACTIVATE_FIRST;
        end
      end
      REQ_THR_UP: begin
        if (rate_up <= {1'b0, thr_limit_r}) begin
          rate_nxt = rate_up[7:0];
        end else begin
          rate_nxt = thr_limit_r;
        end
      end
      REQ_THR_DOWN: begin
        if (rate_r > thr_step_r) begin
          rate_nxt = rate_r - thr_step_r;
        end else begin
          rate_nxt = '0;
        end
      end
      REQ_SET_SPEED: held_nxt = in_item_r.set_value;
      REQ_SET_RATE:  rate_nxt = in_item_r.set_value;
      default: ;
    endcase

    if (engage) begin
      active_nxt = 1'b1;
      susp_nxt   = 1'b0;
      accel_nxt  = 1'b0;
      res_nxt.maintain_write = 1'b1;
      res_nxt.maintain_speed = held_nxt;
      res_nxt.led_write      = 1'b1;
      res_nxt.led_on         = 1'b1;
      res_nxt.message_code   = MSG_SHOW_SPEED;
    end

    res_nxt.cruise_active       = active_nxt;
    res_nxt.cruise_suspended    = susp_nxt;
    res_nxt.cruise_accelerating = accel_nxt;
    res_nxt.held_speed_out      = held_nxt;
    res_nxt.throttle_rate_out   = rate_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      susp_r      <= 1'b0;
      accel_r     <= 1'b0;
      held_r      <= '0;
      rate_r      <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        active_r <= active_nxt;
        susp_r   <= susp_nxt;
        accel_r  <= accel_nxt;
        held_r   <= held_nxt;
        rate_r   <= rate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r  <= req_type_t'(in_tuser);
      in_item_r <= in_item_t'(in_tdata);
    end
    if (fire) begin
      out_item_r <= res_nxt;
    end
  end

endmodule

// ===== hw/rtl/ccm_checker.sv =====
// Port-level checker for the cruise control mode state machine, with its bind statement.
module ccm_checker
  import ccm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  out_item_t res;
  assign res = out_item_t'(out_tdata);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed.");

  a_idle_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.maintain_write || res.maintain_speed == 8'd0) &&
                   (res.led_write || !res.led_on))
    else $error("Command value without a write.");

  a_susp_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.cruise_suspended |-> res.cruise_active)
    else $error("Suspended while not active.");

  a_show_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.message_code == MSG_SHOW_SPEED |->
      res.cruise_active && res.led_on && res.maintain_speed == res.held_speed_out)
    else $error("Engage result inconsistent with status.");

endmodule

bind cruise_control_mode_fsm ccm_checker u_ccm_checker (.*);

// ===== dv/tb_top.sv =====
// Cruise control mode state machine testbench: directed and random events checked against a predictor.
`timescale 1ns / 1ps

import ccm_pkg::*;

class cruise_scoreboard;
  logic [7:0] win_low, win_high, accel_target, thr_step, thr_limit;
  logic [2:0] gear_req;
  logic       active, suspended, accelerating;
  logic [7:0] held_speed, rate;
  out_item_t  expected_status[$];
  int         mismatches;
  int         results_seen;

  function new();
    win_low = SpeedLowRst;
    win_high = SpeedHighRst;
    gear_req = GearRst;
    accel_target = AccelTargetRst;
    thr_step = ThrStepRst;
    thr_limit = ThrLimitRst;
    active = 1'b0;
    suspended = 1'b0;
    accelerating = 1'b0;
    held_speed = 8'd0;
    rate = 8'd0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void set_register(cfg_idx_t idx, logic [7:0] value);
    case (idx)
      CFG_SPEED_LOW:  win_low = value;
      CFG_SPEED_HIGH: win_high = value;
      CFG_GEAR:       gear_req = value[2:0];
      CFG_ACCEL_TGT:  accel_target = value;
      CFG_THR_STEP:   thr_step = value;
      CFG_THR_LIMIT:  thr_limit = value;
      default: ;
    endcase
  endfunction

  function bit request_ok(in_item_t ev);
    if (ev.calibrating || !ev.ignition_on || ev.brake_pressed || ev.clutch_pressed)
      return 1'b0;
    if (ev.engaged_gear != gear_req)
      return 1'b0;
    return (ev.vehicle_speed >= win_low) && (ev.vehicle_speed <= win_high);
  endfunction

  function void engage(inout out_item_t r);
    active = 1'b1;
    suspended = 1'b0;
    accelerating = 1'b0;
    r.maintain_write = 1'b1;
    r.maintain_speed = held_speed;
    r.led_write = 1'b1;
    r.led_on = 1'b1;
    r.message_code = MSG_SHOW_SPEED;
  endfunction

  function void try_activate(in_item_t ev, bit capture, inout out_item_t r);
    if (request_ok(ev)) begin
      if (capture) begin
        held_speed = ev.vehicle_speed;
        rate = ev.throttle_response;
      end
      engage(r);
    end else begin
      r.message_code = MSG_CANNOT_ACTIVATE;
    end
  endfunction

  function out_item_t advance_cruise(logic [3:0] req, in_item_t ev);
    out_item_t  r;
    logic [8:0] raised;
    r = '0;
    r.message_code = MSG_NONE;
    raised = {1'b0, rate} + {1'b0, thr_step};
    case (req)
      REQ_ACTIVATE: try_activate(ev, ev.capture_now, r);
      REQ_DEACTIVATE: begin
        if (active) begin
          held_speed = 8'd0;
          active = 1'b0;
          suspended = 1'b0;
          r.led_write = 1'b1;
          r.maintain_write = 1'b1;
          r.message_code = MSG_DEACTIVATED;
        end else begin
          r.message_code = MSG_ACTIVATE_FIRST;
        end
      end
      REQ_ACCEL_START: begin
        if (active && !suspended) begin
          accelerating = 1'b1;
          suspended = 1'b1;
          r.maintain_write = 1'b1;
          r.maintain_speed = accel_target;
          r.message_code = MSG_ACCELERATING;
        end else begin
          r.message_code = MSG_ACTIVATE_FIRST;
        end
      end
      REQ_ACCEL_STOP: begin
        if (!active) begin
          r.message_code = MSG_ACTIVATE_FIRST;
        end else if (accelerating || ev.accelerator_pressed) begin
          accelerating = 1'b0;
          try_activate(ev, 1'b1, r);
        end else begin
          r.message_code = MSG_ACCEL_FIRST;
        end
      end
      REQ_MAX_SPEED: if (active) engage(r);
      REQ_RESUME: begin
        if (active && !suspended) r.message_code = MSG_ALREADY_ACTIVE;
        else if (suspended) try_activate(ev, 1'b0, r);
        else r.message_code = MSG_ACTIVATE_FIRST;
      end
      REQ_THR_UP: rate = (raised <= {1'b0, thr_limit}) ? raised[7:0] : thr_limit;
      REQ_THR_DOWN: rate = (rate > thr_step) ? rate - thr_step : 8'd0;
      REQ_SET_SPEED: held_speed = ev.set_value;
      REQ_SET_RATE: rate = ev.set_value;
      default: ;
    endcase
    r.cruise_active = active;
    r.cruise_suspended = suspended;
    r.cruise_accelerating = accelerating;
    r.held_speed_out = held_speed;
    r.throttle_rate_out = rate;
    return r;
  endfunction

  function void note_request(logic [3:0] req, in_item_t ev);
    expected_status.push_back(advance_cruise(req, ev));
  endfunction

  function int pending();
    return expected_status.size();
  endfunction

  task report(string what);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task compare(string field, int got, int want);
    if (got != want)
      report($sformatf("result %0d %s got %0d expected %0d", results_seen, field, got, want));
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (expected_status.size() == 0) begin
      report($sformatf("result %0d arrived with no request outstanding", results_seen));
    end else begin
      want = expected_status.pop_front();
      compare("maintain_write", got.maintain_write, want.maintain_write);
      compare("maintain_speed", got.maintain_speed, want.maintain_speed);
      compare("led_write", got.led_write, want.led_write);
      compare("led_on", got.led_on, want.led_on);
      compare("message_code", got.message_code, want.message_code);
      compare("cruise_active", got.cruise_active, want.cruise_active);
      compare("cruise_suspended", got.cruise_suspended, want.cruise_suspended);
      compare("cruise_accelerating", got.cruise_accelerating, want.cruise_accelerating);
      compare("held_speed_out", got.held_speed_out, want.held_speed_out);
      compare("throttle_rate_out", got.throttle_rate_out, want.throttle_rate_out);
      compare("zero fill", got.pad, want.pad);
    end
    results_seen++;
  endtask

  task flush_leftovers();
    while (expected_status.size() != 0) begin
      void'(expected_status.pop_front());
      report("expected result never arrived");
    end
  endtask
endclass

module tb_top;

  localparam logic [3:0] ReqUnusedLo = 4'd10;
  localparam logic [3:0] ReqUnusedHi = 4'd15;
  localparam int HoldCycles = 300;
  localparam int Latency = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata = '0;
  logic [3:0]           in_tuser = 4'd0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  bit no_idle = 1'b0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  cruise_scoreboard sb = new();

  cruise_control_mode_fsm dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HoldCycles;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_item_t'(out_tdata));
  end

  task automatic send_request(logic [3:0] req, in_item_t ev);
    if (!no_idle && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= ev;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, ev);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] lo, logic [7:0] hi, logic [2:0] gear,
                                logic [7:0] accel, logic [7:0] step, logic [7:0] limit);
    write_reg(CFG_SPEED_LOW, lo);
    write_reg(CFG_SPEED_HIGH, hi);
    write_reg(CFG_GEAR, {5'd0, gear});
    write_reg(CFG_ACCEL_TGT, accel);
    write_reg(CFG_THR_STEP, step);
    write_reg(CFG_THR_LIMIT, limit);
  endtask

  // A snapshot that passes every engage condition but the speed window, which depends on the speed given.
  function automatic in_item_t good_snapshot(logic [7:0] speed, logic [7:0] resp);
    in_item_t ev;
    ev = '0;
    ev.vehicle_speed = speed;
    ev.throttle_response = resp;
    ev.ignition_on = 1'b1;
    ev.engaged_gear = sb.gear_req;
    return ev;
  endfunction

  function automatic in_item_t random_snapshot();
    in_item_t    ev;
    logic [7:0]  speed;
    int          pick;
    pick = $urandom_range(99);
    if (sb.win_low <= sb.win_high) begin
      case ($urandom_range(3))
        0: speed = sb.win_low;
        1: speed = sb.win_high;
        default: speed = 8'($urandom_range(sb.win_high, sb.win_low));
      endcase
    end else begin
      speed = 8'($urandom_range(255));
    end
    ev = good_snapshot(speed, 8'($urandom_range(255)));
    ev.capture_now = 1'($urandom_range(1));
    ev.accelerator_pressed = 1'($urandom_range(1));
    ev.set_value = 8'($urandom_range(255));
    if (pick >= 88) begin
      ev = in_item_t'(40'({$urandom, $urandom}));
      ev.pad = '0;
    end else if (pick >= 75) begin
      case ($urandom_range(5))
        0: ev.calibrating = 1'b1;
        1: ev.ignition_on = 1'b0;
        2: ev.brake_pressed = 1'b1;
        3: ev.clutch_pressed = 1'b1;
        4: ev.engaged_gear = sb.gear_req + 3'($urandom_range(7, 1));
        default: ev.vehicle_speed = 8'($urandom_range(255));
      endcase
    end
    return ev;
  endfunction

  function automatic logic [3:0] random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 14) return REQ_ACTIVATE;
    if (pick < 22) return REQ_DEACTIVATE;
    if (pick < 34) return REQ_ACCEL_START;
    if (pick < 46) return REQ_ACCEL_STOP;
    if (pick < 54) return REQ_MAX_SPEED;
    if (pick < 66) return REQ_RESUME;
    if (pick < 74) return REQ_THR_UP;
    if (pick < 82) return REQ_THR_DOWN;
    if (pick < 88) return REQ_SET_SPEED;
    if (pick < 94) return REQ_SET_RATE;
    return 4'($urandom_range(ReqUnusedHi, ReqUnusedLo));
  endfunction

  task automatic random_requests(int count);
    logic [3:0] req;
    int         done;
    done = 0;
    while (done < count) begin
      req = random_request();
      send_request(req, random_snapshot());
      done++;
    end
  endtask

  task automatic directed_requests();
    in_item_t ev;
    ev = good_snapshot(8'd100, 8'd20);
    send_request(REQ_DEACTIVATE, ev);
    send_request(REQ_ACCEL_START, ev);
    send_request(REQ_MAX_SPEED, ev);
    send_request(REQ_RESUME, ev);
    ev = good_snapshot(8'd0, 8'd0);
    ev.calibrating = 1'b1;
    send_request(REQ_ACTIVATE, ev);
    ev = good_snapshot(8'd100, 8'd20);
    ev.ignition_on = 1'b0;
    send_request(REQ_ACTIVATE, ev);
    ev = good_snapshot(8'd100, 8'd20);
    ev.brake_pressed = 1'b1;
    send_request(REQ_ACTIVATE, ev);
    ev = good_snapshot(8'd100, 8'd20);
    ev.clutch_pressed = 1'b1;
    send_request(REQ_ACTIVATE, ev);
    ev = good_snapshot(8'd100, 8'd20);
    ev.engaged_gear = 3'd7;
    send_request(REQ_ACTIVATE, ev);
    send_request(REQ_ACTIVATE, good_snapshot(SpeedLowRst - 8'd1, 8'd20));
    send_request(REQ_ACTIVATE, good_snapshot(SpeedHighRst + 8'd1, 8'd20));
    ev = good_snapshot(SpeedLowRst, 8'd255);
    ev.capture_now = 1'b1;
    send_request(REQ_ACTIVATE, ev);
    send_request(REQ_THR_UP, ev);
    ev.set_value = 8'd3;
    send_request(REQ_SET_RATE, ev);
    send_request(REQ_THR_DOWN, ev);
    send_request(REQ_ACTIVATE, good_snapshot(SpeedHighRst, 8'd9));
    send_request(REQ_RESUME, ev);
    send_request(REQ_ACCEL_START, ev);
    send_request(REQ_DEACTIVATE, ev);
    ev = good_snapshot(8'd150, 8'd0);
    ev.capture_now = 1'b1;
    send_request(REQ_ACTIVATE, ev);
    send_request(REQ_ACCEL_START, ev);
    send_request(REQ_RESUME, ev);
    send_request(REQ_ACCEL_STOP, ev);
    ev.accelerator_pressed = 1'b1;
    send_request(REQ_ACCEL_STOP, ev);
    send_request(REQ_ACCEL_START, ev);
    ev.brake_pressed = 1'b1;
    send_request(REQ_ACCEL_STOP, ev);
    send_request(REQ_MAX_SPEED, ev);
    ev.set_value = 8'd255;
    send_request(REQ_SET_SPEED, ev);
    send_request(ReqUnusedHi, ev);
    send_request(ReqUnusedLo, ev);
  endtask

  initial begin
    logic [7:0] lo;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_requests();
    random_requests(250);
    wait_results();

    apply_settings(8'd0, 8'd255, 3'd0, 8'd0, 8'd1, 8'd255);
    no_idle <= 1'b1;
    random_requests(300);
    no_idle <= 1'b0;
    wait_results();

    apply_settings(8'd255, 8'd255, 3'd7, 8'd255, 8'd255, 8'd0);
    hold_asked <= hold_asked + 1;
    random_requests(250);
    wait_results();

    apply_settings(8'd200, 8'd100, 3'd3, 8'd128, 8'd255, 8'd255);
    random_requests(200);
    wait_results();

    repeat (3) begin
      lo = 8'($urandom_range(200));
      apply_settings(lo, 8'($urandom_range(255, lo)), 3'($urandom_range(7)),
                     8'($urandom_range(255)), 8'($urandom_range(255, 1)),
                     8'($urandom_range(255)));
      hold_asked <= hold_asked + 1;
      random_requests(135);
      wait_results();
      random_requests(135);
      wait_results();
    end

    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
